// ===== hw/rtl/ubh_pkg.sv =====
// Shared types, widths and codes of the uniform bin histogram unit.
`default_nettype none

package ubh_pkg;

    localparam int MODE_W    = 2;
    localparam int SAMPLE_W  = 24;
    localparam int BIN_W     = 10;
    localparam int COUNT_W   = 32;
    localparam int LB_W      = 24;
    localparam int BW_W      = 23;
    localparam int NB_W      = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    // Difference of two 24-bit signed values, and the signed bin number.
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int Q_W    = DIFF_W + 1;

    // Divider operand widths.
    localparam int DVD_W = SAMPLE_W;
    localparam int DVS_W = BW_W;

    localparam int DEF_MAX_BINS = 1024;

    localparam logic [LB_W-1:0] LB_RESET = 24'd0;
    localparam logic [BW_W-1:0] BW_RESET = 23'd256;
    localparam logic [NB_W-1:0] NB_RESET = 11'd100;
    localparam logic            TR_RESET = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_BOUND = 2'd0,
        CFG_BIN_WIDTH   = 2'd1,
        CFG_NUM_BINS    = 2'd2,
        CFG_TRUNCATE    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic signed [SAMPLE_W-1:0] sample;
        logic [BIN_W-1:0]           bin_index;
    } hist_in_t;

    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic               counted;
        logic [COUNT_W-1:0] count;
    } hist_out_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ubh_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module ubh_divider (
    input  wire              clk,
    input  wire              rst_n,
    input  ubh_pkg::div_req_t req,
    output ubh_pkg::div_rsp_t rsp
);
    import ubh_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_sub;
    logic             fits;

    // Next dividend bit joins the partial remainder; subtract if it fits.
    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(DVD_W - 1);
            dvd_next = req.dividend;
            dvs_next = req.divisor;
            rem_next = '0;
            quo_next = '0;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ubh_bin_store.sv =====
// Bin count memory: one write port and one registered read port.
`default_nettype none

module ubh_bin_store #(
    parameter int MAX_BINS = ubh_pkg::DEF_MAX_BINS
) (
    input  wire                             clk,
    input  wire                             we,
    input  wire [$clog2(MAX_BINS)-1:0]      waddr,
    input  wire [ubh_pkg::COUNT_W-1:0]      wdata,
    input  wire [$clog2(MAX_BINS)-1:0]      raddr,
    output logic [ubh_pkg::COUNT_W-1:0]     rdata
);
    import ubh_pkg::*;

    logic [COUNT_W-1:0] mem [MAX_BINS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/uniform_bin_histogram_unit.sv =====
// Top level of the uniform bin histogram unit: configuration, control and result register.
//
//  Channel  Ports                              Transfer
//  cmd      start, busy, cmd                   item taken when start and not busy
//  result   done, result                       item shown for one cycle while done is high
//  config   cfg_we, cfg_index, cfg_data        register written when cfg_we is high
//
// An add item passes from acceptance to the edge that takes its result through the
// bit-serial divider, the passing of its done flag, the bin range check, the
// read-modify-write of the bin memory and the result register. A read item passes
// through the memory read and the result register; a clear item zeroes one memory
// entry per cycle. After reset the same clearing pass runs with busy high.
// Results are never held off by the receiver.
`default_nettype none

module uniform_bin_histogram_unit #(
    parameter int MAX_BINS = ubh_pkg::DEF_MAX_BINS
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  ubh_pkg::hist_in_t                cmd,
    output logic                             done,
    output ubh_pkg::hist_out_t               result,
    input  wire                              cfg_we,
    input  wire [ubh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [ubh_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ubh_pkg::*;

    localparam int IDXW   = $clog2(MAX_BINS);
    localparam int CNT_CW = $clog2(MAX_BINS + 1);
    localparam int CW     = (CNT_CW > NB_W) ? CNT_CW : NB_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_RANGE = 6'b000100,
        ST_FETCH = 6'b001000,
        ST_APPLY = 6'b010000,
        ST_CLEAR = 6'b100000
    } state_t;

    // Configuration registers.
    logic signed [LB_W-1:0] lb_reg;
    logic [BW_W-1:0]        bw_reg;
    logic [NB_W-1:0]        nb_reg;
    logic                   tr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lb_reg <= LB_RESET;
            bw_reg <= BW_RESET;
            nb_reg <= NB_RESET;
            tr_reg <= TR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOWER_BOUND: lb_reg <= cfg_data[LB_W-1:0];
                CFG_BIN_WIDTH:   bw_reg <= cfg_data[BW_W-1:0];
                CFG_NUM_BINS:    nb_reg <= cfg_data[NB_W-1:0];
                CFG_TRUNCATE:    tr_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    state_t             state_reg, state_next;
    logic [IDXW-1:0]    addr_reg, addr_next;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic               kind_reg, kind_next;      // 1 for an add item
    logic               rd_ok_reg, rd_ok_next;
    logic               neg_reg, neg_next;
    logic               clr_item_reg, clr_item_next;
    logic [IDXW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic               done_reg, done_next;
    hist_out_t          result_reg, result_next;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic               mem_we;
    logic [IDXW-1:0]    mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;
    logic [COUNT_W-1:0] mem_rdata;
    logic [COUNT_W-1:0] count_inc;

    // Effective bin width and bin count.
    logic [BW_W-1:0]    w_eff;
    logic [CW-1:0]      nb_c;
    logic [CW-1:0]      n_c;
    logic [CW-1:0]      n_m1;
    logic [Q_W-2:0]     n_q;

    assign w_eff = (bw_reg == '0) ? BW_W'(1) : bw_reg;
    assign nb_c  = CW'(nb_reg);
    assign n_c   = (nb_reg == '0) ? CW'(1)
                 : ((nb_c > CW'(MAX_BINS)) ? CW'(MAX_BINS) : nb_c);
    assign n_m1  = n_c - CW'(1);
    assign n_q   = (Q_W-1)'(n_c);

    // Floor division of a negative difference d is -((-d-1)/w)-1, and -d-1 is ~d.
    logic [DIFF_W-1:0]  diff;
    logic [DVD_W-1:0]   mag;

    assign diff = {cmd.sample[SAMPLE_W-1], cmd.sample} - {lb_reg[LB_W-1], lb_reg};
    assign mag  = diff[DIFF_W-1] ? ~diff[DVD_W-1:0] : diff[DVD_W-1:0];

    assign div_req.start    = start && (state_reg == ST_IDLE) && (cmd.mode == MODE_ADD);
    assign div_req.dividend = mag;
    assign div_req.divisor  = w_eff;

    ubh_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Signed bin number and its range check.
    logic [Q_W-1:0]     q;
    logic [Q_W-2:0]     q_mag;
    logic               below;
    logic               above;
    logic               drop;
    logic [IDXW-1:0]    idx;

    assign q     = neg_reg ? ~{2'b00, div_rsp.quotient} : {2'b00, div_rsp.quotient};
    assign q_mag = q[Q_W-2:0];
    assign below = q[Q_W-1];
    assign above = !q[Q_W-1] && (q_mag >= n_q);
    assign drop  = !tr_reg && (below || above);
    assign idx   = below ? '0 : (above ? IDXW'(n_m1) : IDXW'(q_mag));

    assign count_inc = (mem_rdata == '1) ? mem_rdata : mem_rdata + COUNT_W'(1);

    ubh_bin_store #(
        .MAX_BINS (MAX_BINS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        bin_next      = bin_reg;
        kind_next     = kind_reg;
        rd_ok_next    = rd_ok_reg;
        neg_next      = neg_reg;
        clr_item_next = clr_item_reg;
        clr_cnt_next  = clr_cnt_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = count_inc;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.mode)
                        MODE_ADD:
                        begin
                            neg_next   = diff[DIFF_W-1];
                            state_next = ST_DIV;
                        end
                        MODE_READ:
                        begin
                            addr_next  = IDXW'(cmd.bin_index);
                            bin_next   = cmd.bin_index;
                            rd_ok_next = (32'(cmd.bin_index) < 32'(MAX_BINS));
                            kind_next  = 1'b0;
                            state_next = ST_FETCH;
                        end
                        MODE_CLEAR:
                        begin
                            clr_cnt_next  = '0;
                            clr_item_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                if (drop)
                begin
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    addr_next  = idx;
                    bin_next   = BIN_W'(idx);
                    kind_next  = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                done_next       = 1'b1;
                result_next.bin = bin_reg;
                if (kind_reg)
                begin
                    mem_we              = 1'b1;
                    result_next.counted = 1'b1;
                    result_next.count   = count_inc;
                end
                else
                begin
                    result_next.counted = 1'b0;
                    result_next.count   = rd_ok_reg ? mem_rdata : '0;
                end
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == IDXW'(MAX_BINS - 1))
                begin
                    state_next = ST_IDLE;
                    // The pass after reset has no item to answer.
                    if (clr_item_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDXW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_item_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_item_reg <= clr_item_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        bin_reg    <= bin_next;
        kind_reg   <= kind_next;
        rd_ok_reg  <= rd_ok_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
